[hw/rtl/lesf_pkg.sv]
// Shared types and constants for the largest empty square finder.
package lesf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 11;

  typedef enum logic [CfgIndexW-1:0] {
    REG_COLUMN_COUNT = 2'd0,
    REG_EMPTY_CHAR   = 2'd1
  } cfg_reg_t;

  localparam logic [10:0] ColumnCountReset = 11'd1;
  localparam logic [7:0]  EmptyCharReset   = 8'd46;

  typedef struct packed {
    logic [7:0] cell_byte;
    logic       last_cell;
  } cell_t;

  typedef struct packed {
    logic [10:0] square_size;
    logic [9:0]  bottom_row;
    logic [9:0]  right_col;
  } result_t;

endpackage

[hw/rtl/largest_empty_square_finder_core.sv]
// Largest empty square finder: streaming maximal-square search over a raster grid.
//
// The block takes one grid cell per clock, in raster order, except where a last cell
// waits as described below. Each cell's run value is formed combinationally from the cell
// above (held in a MAX_COLS-entry line buffer whose registered read for the
// next column is issued while the current cell transfers), the cell to the left
// and the cell up-left. The transfer flagged last_cell loads one result (size and
// bottom-right corner of the first largest empty square) into the output register,
// and the row and column counters restart for the next grid. Cells that do not end a
// grid are taken even while a result waits on result_ready; a last cell waits
// until the output register is free. The line buffer needs no clearing after reset.
module largest_empty_square_finder_core
  import lesf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 cell_valid,
  output logic                 cell_ready,
  input  cell_t                grid_cell,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RunW  = $clog2(MAX_COLS + 1);
  localparam int CntRaw = $clog2(MAX_COLS + 2);
  localparam int CntW  = (CntRaw > CfgDataW) ? CntRaw : CfgDataW;

  logic [10:0]     column_count;
  logic [7:0]      empty_char;
  logic [ColW-1:0] col_index;
  logic [RowW-1:0] row_index;
  logic [RunW-1:0] left_run;
  logic [RunW-1:0] diag_run;
  logic [RunW-1:0] best_size;
  logic [RowW-1:0] best_row;
  logic [ColW-1:0] best_col;

  logic [CntW-1:0] eff_cols;
  logic [CntW-1:0] col_inc;
  logic            row_wrap;
  logic [ColW-1:0] col_adv;
  logic [RowW-1:0] row_adv;
  logic [ColW-1:0] col_index_next;
  logic [RowW-1:0] row_index_next;
  logic [ColW-1:0] rd_addr;
  logic [RunW-1:0] up_run;
  logic [RunW-1:0] min_lu;
  logic [RunW-1:0] min_all;
  logic [RunW-1:0] run;
  logic            run_better;
  logic [RunW-1:0] best_size_next;
  logic [RowW-1:0] best_row_next;
  logic [ColW-1:0] best_col_next;
  logic            cell_xfer;

  assign cfg_ready  = 1'b1;
  assign cell_ready = !result_valid || result_ready || !grid_cell.last_cell;
  assign cell_xfer  = cell_valid && cell_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= ColumnCountReset;
      empty_char   <= EmptyCharReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_COLUMN_COUNT: column_count <= cfg_data;
        REG_EMPTY_CHAR:   empty_char   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (column_count == '0) begin
      eff_cols = CntW'(1);
    end else if (CntW'(column_count) > CntW'(MAX_COLS)) begin
      eff_cols = CntW'(MAX_COLS);
    end else begin
      eff_cols = CntW'(column_count);
    end
  end

  assign col_inc  = CntW'(col_index) + CntW'(1);
  assign row_wrap = (col_inc >= eff_cols);
  assign col_adv  = row_wrap ? '0 : ColW'(col_inc);
  assign row_adv  = (row_wrap && (row_index != RowW'(MAX_ROWS - 1))) ?
                    row_index + RowW'(1) : row_index;

  assign col_index_next = grid_cell.last_cell ? '0 : col_adv;
  assign row_index_next = grid_cell.last_cell ? '0 : row_adv;
  assign rd_addr        = cell_xfer ? col_index_next : col_index;

  assign min_lu  = (up_run < left_run) ? up_run : left_run;
  assign min_all = (min_lu < diag_run) ? min_lu : diag_run;

  always_comb begin
    if (grid_cell.cell_byte != empty_char) begin
      run = '0;
    end else if ((row_index == '0) || (col_index == '0)) begin
      run = RunW'(1);
    end else begin
      run = min_all + RunW'(1);
    end
  end

  assign run_better     = (run > best_size);
  assign best_size_next = run_better ? run : best_size;
  assign best_row_next  = run_better ? row_index : best_row;
  assign best_col_next  = run_better ? col_index : best_col;

  lesf_line_buf #(
    .Depth(MAX_COLS),
    .AddrW(ColW),
    .DataW(RunW)
  ) u_line_buf (
    .clk    (clk),
    .wr_en  (cell_xfer),
    .wr_addr(col_index),
    .wr_data(run),
    .rd_addr(rd_addr),
    .rd_data(up_run)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      row_index <= '0;
      left_run  <= '0;
      diag_run  <= '0;
      best_size <= '0;
      best_row  <= '0;
      best_col  <= '0;
    end else if (cell_xfer) begin
      col_index <= col_index_next;
      row_index <= row_index_next;
      if (grid_cell.last_cell) begin
        left_run  <= '0;
        diag_run  <= '0;
        best_size <= '0;
        best_row  <= '0;
        best_col  <= '0;
      end else begin
        left_run  <= run;
        diag_run  <= up_run;
        best_size <= best_size_next;
        best_row  <= best_row_next;
        best_col  <= best_col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cell_xfer && grid_cell.last_cell) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_xfer && grid_cell.last_cell) begin
      result.square_size <= 11'(best_size_next);
      result.bottom_row  <= 10'(best_row_next);
      result.right_col   <= 10'(best_col_next);
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    cell_xfer && grid_cell.last_cell |=> result_valid)
    else $error("last cell transfer did not load a result");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    cell_xfer && grid_cell.last_cell |=> (col_index == '0) && (row_index == '0) &&
                                         (best_size == '0))
    else $error("counters not cleared after last cell");

  a_best_tracks_run: assert property (@(posedge clk) disable iff (rst)
    cell_xfer && !grid_cell.last_cell && run_better |=> best_size == $past(run))
    else $error("best size missed a larger run");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !(cell_xfer && grid_cell.last_cell))
    else $error("last cell taken while result stalled");

endmodule

[hw/rtl/lesf_line_buf.sv]
// One-row line buffer with registered read and write-to-read bypass.
module lesf_line_buf #(
  parameter int Depth = 1024,
  parameter int AddrW = 10,
  parameter int DataW = 11
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [DataW-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [DataW-1:0] rd_data
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the largest empty square finder core.
module tb
  import lesf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCols    = 1024;
  localparam int MaxRows    = 1024;
  localparam int HoldCycles = 400;
  localparam int StuckLimit = 4000;
  localparam int PhaseItems = 30;
  localparam int GridCap    = 60;

  class square_tracker;
    logic [10:0] col_count;
    logic [7:0]  empty_byte;
    logic [10:0] line_runs [MaxCols];
    logic [10:0] left_run, diag_run, best_size;
    logic [9:0]  row_idx, col_idx, best_row, best_col;
    result_t     expected_squares [$];
    int          errors;

    function new();
      col_count  = ColumnCountReset;
      empty_byte = EmptyCharReset;
      foreach (line_runs[i]) line_runs[i] = '0;
      errors = 0;
      clear_grid();
    endfunction

    function void clear_grid();
      left_run  = '0;
      diag_run  = '0;
      row_idx   = '0;
      col_idx   = '0;
      best_size = '0;
      best_row  = '0;
      best_col  = '0;
    endfunction

    function int eff_cols();
      if (col_count == 0) return 1;
      if (col_count > MaxCols) return MaxCols;
      return int'(col_count);
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_COLUMN_COUNT: col_count = data;
        REG_EMPTY_CHAR:   empty_byte = data[7:0];
        default: ;
      endcase
    endfunction

    function void take_cell(cell_t c);
      logic [10:0] up, run;
      result_t     sq;
      up = line_runs[col_idx];
      if (c.cell_byte != empty_byte) begin
        run = '0;
      end else if (row_idx == 0 || col_idx == 0) begin
        run = 11'd1;
      end else begin
        run = (left_run < diag_run) ? left_run : diag_run;
        if (up < run) run = up;
        run = run + 11'd1;
      end
      if (run > best_size) begin
        best_size = run;
        best_row  = row_idx;
        best_col  = col_idx;
      end
      diag_run = up;
      left_run = run;
      line_runs[col_idx] = run;
      if (col_idx + 1 >= eff_cols()) begin
        col_idx = '0;
        if (row_idx + 1 < MaxRows) row_idx = row_idx + 10'd1;
      end else begin
        col_idx = col_idx + 10'd1;
      end
      if (c.last_cell) begin
        sq.square_size = best_size;
        sq.bottom_row  = best_row;
        sq.right_col   = best_col;
        expected_squares.push_back(sq);
        clear_grid();
      end
    endfunction

    function void check_square(result_t got);
      result_t want;
      if (expected_squares.size() == 0) begin
        errors++;
        $display("%0t: unexpected result size %0d row %0d col %0d", $time,
                 got.square_size, got.bottom_row, got.right_col);
        return;
      end
      want = expected_squares.pop_front();
      if (got.square_size !== want.square_size) begin
        errors++;
        $display("%0t: square_size expected %0d got %0d", $time,
                 want.square_size, got.square_size);
      end
      if (got.bottom_row !== want.bottom_row) begin
        errors++;
        $display("%0t: bottom_row expected %0d got %0d", $time,
                 want.bottom_row, got.bottom_row);
      end
      if (got.right_col !== want.right_col) begin
        errors++;
        $display("%0t: right_col expected %0d got %0d", $time,
                 want.right_col, got.right_col);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = REG_COLUMN_COUNT;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 cell_valid = 1'b0;
  logic                 cell_ready;
  cell_t                grid_cell = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;

  square_tracker tracker;
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  logic          hold_start = 1'b0;
  int            hold_left = 0;
  int            stuck_cycles = 0;
  logic [10:0]   grid_cols = ColumnCountReset;
  logic [7:0]    grid_empty = EmptyCharReset;
  int            phase_cols [12] = '{1, 4, 0, 9, 2, 16, 3, 33, 6, 1024, 12, 5};

  largest_empty_square_finder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .grid_cell    (grid_cell),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) tracker.check_square(result);
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (cell_valid && cell_ready) tracker.take_cell(grid_cell);
    end
  end

  always @(posedge clk) begin
    if (hold_start) begin
      hold_start <= 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (cell_valid && cell_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stuck_cycles++;
    end
  end

  task automatic configure(logic [10:0] cols, logic [7:0] empty);
    grid_cols  = cols;
    grid_empty = empty;
    cfg_valid <= 1'b1;
    cfg_index <= REG_COLUMN_COUNT;
    cfg_data  <= cols;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_EMPTY_CHAR;
    cfg_data  <= {3'b000, empty};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    grid_cell  <= cell_t'{cell_byte: b, last_cell: last};
    @(posedge clk);
    while (!cell_ready) @(posedge clk);
  endtask

  task automatic send_cells(int count, int empty_pct, logic ends_grid);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < empty_pct) b = grid_empty;
      else if (b == grid_empty) b = ~b;
      offer_byte(b, ends_grid && (i == count - 1));
    end
  endtask

  task automatic send_grid(output int n);
    int cols;
    int pct;
    cols = (grid_cols == 0) ? 1 : ((grid_cols > MaxCols) ? MaxCols : int'(grid_cols));
    n = $urandom_range(1, 8) * cols;
    if (cols > 1 && $urandom_range(0, 3) == 0) n -= $urandom_range(1, cols - 1);
    if (n > GridCap) n = $urandom_range(1, GridCap);
    case ($urandom_range(0, 2))
      0: pct = 60;
      1: pct = 85;
      default: pct = 97;
    endcase
    send_cells(n, pct, 1'b1);
  endtask

  // hold until every expected square is back and the core has settled
  task automatic drain();
    cell_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_squares.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int sent;
    int n;
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    offer_byte(8'd46, 1'b1);
    offer_byte(8'd255, 1'b1);
    drain();
    configure(11'd0, 8'd0);
    offer_byte(8'd0, 1'b0);
    offer_byte(8'd0, 1'b0);
    offer_byte(8'd0, 1'b1);
    drain();
    configure(11'd3, 8'd255);
    send_cells(9, 100, 1'b1);
    drain();
    // lower the column count in the middle of a row
    configure(11'd4, 8'd46);
    send_cells(6, 100, 1'b0);
    drain();
    configure(11'd2, 8'd46);
    send_cells(3, 100, 1'b1);
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p / 3)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      configure(11'(phase_cols[p]),
                (p == 0) ? 8'd0 : ((p == 1) ? 8'd255 : 8'($urandom_range(0, 255))));
      if (p == 0) begin
        hold_start <= 1'b1;
        for (int g = 0; g < 40; g++) send_cells($urandom_range(1, 3), 85, 1'b1);
      end
      sent = 0;
      while (sent < PhaseItems) begin
        send_grid(n);
        sent += n;
      end
      drain();
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // advance past the last row index; the row counter must saturate
    configure(11'd1, 8'($urandom_range(0, 255)));
    send_cells(MaxRows - 1, 0, 1'b0);
    send_cells(7, 100, 1'b1);
    drain();
    configure(11'd2047, 8'($urandom_range(0, 255)));
    send_cells(40, 97, 1'b1);
    drain();

    repeat (16) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_squares.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
